>>> hdl/zbpe_pkg.sv
// Package for the zero-byte pack encoder: item and group types, sizes,
// and the bit-scan helper used by the byte emitter.
// No dependencies.
package zbpe_pkg;

    localparam int GROUP_SIZE     = 8;
    localparam int IDX_W          = $clog2(GROUP_SIZE);
    localparam int CNT_W          = IDX_W + 1;
    localparam int QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       stream_end;
    } t_out_item;

    // One closed group as the front end hands it to the emitter.
    typedef struct packed {
        logic [GROUP_SIZE-1:0][7:0] bytes;
        logic [GROUP_SIZE-1:0]      mask;
        logic [CNT_W-1:0]           count;
        logic                       last;
    } t_group;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [IDX_W-1:0] lowest_set(input logic [GROUP_SIZE-1:0] bits);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            if (bits[j]) begin
                idx = IDX_W'(j);
            end
        end
        return idx;
    endfunction

endpackage

>>> hdl/zbpe_front.sv
// Group front end: accepts raw bytes, stores them, builds the nonzero mask
// and pushes each closed group to the group queue. Depends on zbpe_pkg.
module zbpe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  zbpe_pkg::t_in_item i_in_item,
    input  logic              i_full,
    output logic              o_push,
    output zbpe_pkg::t_group  o_group
);

    logic [zbpe_pkg::GROUP_SIZE-1:0][7:0] r_store;
    logic [zbpe_pkg::GROUP_SIZE-1:0]      r_mask;
    logic [zbpe_pkg::GROUP_SIZE-1:0]      n_mask;
    logic [zbpe_pkg::IDX_W-1:0]           r_fill;
    logic [zbpe_pkg::IDX_W-1:0]           n_fill;
    logic                                 w_accept;
    logic                                 w_close;

    assign o_in_stall = i_full;
    assign w_accept   = i_in_valid & ~i_full;
    assign w_close    = (r_fill == zbpe_pkg::IDX_W'(zbpe_pkg::GROUP_SIZE - 1))
                        | i_in_item.final_byte;

    always_comb begin
        n_mask = r_mask;
        if (i_in_item.data_byte != 8'd0) begin
            n_mask[r_fill] = 1'b1;
        end
        for (int j = 0; j < zbpe_pkg::GROUP_SIZE; j++) begin
            o_group.bytes[j] = (r_fill == zbpe_pkg::IDX_W'(j)) ? i_in_item.data_byte
                                                                 : r_store[j];
        end
        o_group.mask  = n_mask;
        o_group.count = zbpe_pkg::CNT_W'(r_fill) + zbpe_pkg::CNT_W'(1);
        o_group.last  = i_in_item.final_byte;
        o_push        = w_accept & w_close;
        n_fill        = w_close ? '0 : r_fill + zbpe_pkg::IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_store[r_fill] <= i_in_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_mask <= '0;
        end else if (w_accept) begin
            r_fill <= n_fill;
            r_mask <= w_close ? '0 : n_mask;
        end
    end

endmodule

>>> hdl/zbpe_queue.sv
// Small queue of closed groups between the front end and the emitter.
// Depends on zbpe_pkg for the group type.
module zbpe_queue #(
    parameter int DEPTH = zbpe_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  zbpe_pkg::t_group i_group,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_head_valid,
    output zbpe_pkg::t_group o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    zbpe_pkg::t_group r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full       = (r_cnt == CNT_W'(DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_slot[r_rd];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/zbpe_back.sv
// Byte emitter: walks the group at the queue head and sends the flag byte,
// the kept bytes and, for the last group, the count byte. Depends on zbpe_pkg.
module zbpe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  zbpe_pkg::t_group   i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output zbpe_pkg::t_out_item o_out_item
);

    localparam logic [1:0] ST_FLAG  = 2'd0;
    localparam logic [1:0] ST_DATA  = 2'd1;
    localparam logic [1:0] ST_COUNT = 2'd2;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [zbpe_pkg::GROUP_SIZE-1:0] r_left;
    logic [zbpe_pkg::GROUP_SIZE-1:0] n_left;
    logic [zbpe_pkg::GROUP_SIZE-1:0] w_rest;
    logic [zbpe_pkg::IDX_W-1:0]      w_idx;
    zbpe_pkg::t_out_item             r_out;
    zbpe_pkg::t_out_item             n_out;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic                            w_load;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_load      = ~r_out_valid | ~i_out_stall;
    assign w_idx       = zbpe_pkg::lowest_set(r_left);

    always_comb begin
        w_rest = r_left;
        w_rest[w_idx] = 1'b0;
    end

    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        o_pop       = 1'b0;
        case (r_state)
            ST_FLAG: begin
                if (i_head_valid && w_load) begin
                    n_out.packed_byte = i_head.mask;
                    n_out.stream_end  = 1'b0;
                    n_out_valid       = 1'b1;
                    n_left            = i_head.mask;
                    if (i_head.mask != '0) begin
                        n_state = ST_DATA;
                    end else if (i_head.last) begin
                        n_state = ST_COUNT;
                    end else begin
                        o_pop = 1'b1;
                    end
                end
            end
            ST_DATA: begin
                if (w_load) begin
                    n_out.packed_byte = i_head.bytes[w_idx];
                    n_out.stream_end  = 1'b0;
                    n_out_valid       = 1'b1;
                    n_left            = w_rest;
                    if (w_rest == '0) begin
                        if (i_head.last) begin
                            n_state = ST_COUNT;
                        end else begin
                            o_pop   = 1'b1;
                            n_state = ST_FLAG;
                        end
                    end
                end
            end
            ST_COUNT: begin
                if (w_load) begin
                    n_out.packed_byte = 8'(i_head.count);
                    n_out.stream_end  = 1'b1;
                    n_out_valid       = 1'b1;
                    o_pop             = 1'b1;
                    n_state           = ST_FLAG;
                end
            end
            default: begin
                n_state = ST_FLAG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_left <= n_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FLAG;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hdl/zero_byte_pack_encoder_core.sv
// Zero-byte pack encoder: takes one raw byte per item, groups eight bytes and
// sends a flag byte (bit j set when byte j is nonzero) followed by the
// nonzero bytes; the last group of a stream, which may be short, is followed
// by a count byte (1 to 8) that carries stream_end. Bytes enter at one per
// cycle while the group queue has room; results leave at one byte per cycle
// while the output is not stalled. A group sends its flag byte and its kept
// bytes, and the last group also sends the count byte. The output byte port
// is what limits the sustained rate for dense data in long streams (nine
// output bytes per eight input bytes).
// Depends on zbpe_pkg, zbpe_front, zbpe_queue and zbpe_back.
module zero_byte_pack_encoder_core #(
    parameter int QUEUE_DEPTH = zbpe_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  zbpe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output zbpe_pkg::t_out_item o_out_item
);

    // Closed groups travel from the front end to the emitter through the
    // queue; the front end stalls the input only while the queue is full.
    logic             w_full;
    logic             w_push;
    logic             w_pop;
    logic             w_head_valid;
    zbpe_pkg::t_group w_group;
    zbpe_pkg::t_group w_head;

    zbpe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_group    (w_group)
    );

    // The queue entry stays at the head until the emitter has sent its last
    // byte, so the emitter reads the group straight out of the queue.
    zbpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_group      (w_group),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // The emitter owns the output register, so a waiting result holds up only
    // the emitter; the front end keeps taking bytes until the queue fills.
    zbpe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item)
    );

endmodule
